### src/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the byte stuffing codec
// Symbol codes, the result record and the CRC-8 next-state function.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  // stuffing symbols
  localparam logic [7:0] SymEsc    = 8'hA9;
  localparam logic [7:0] SymSyn    = 8'hAA;
  localparam logic [7:0] SymEscSyn = 8'h01;
  localparam logic [7:0] SymEscEsc = 8'h00;

  // crc-8 generator polynomial
  localparam logic [7:0] CrcPoly = 8'h9B;

  // number of results produced by one item
  localparam logic [1:0] CountNone = 2'd0;
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountTwo  = 2'd2;

  // one result byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] running_crc;
    logic       is_last;
  } scc_res_t;

  // the results of one item, first result in r0
  typedef struct packed {
    logic [1:0] count;
    scc_res_t   r0;
    scc_res_t   r1;
  } scc_pair_t;

  // crc advanced by eight zero bits (linear in crc, a small xor matrix)
  function automatic logic [7:0] crc_shift8(input logic [7:0] crc);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // crc after one more byte: the data bits shift in at the bottom
  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
    return crc_shift8(crc) ^ b;
  endfunction

endpackage

`default_nettype wire

### src/scc_step.sv
// ----------------------------------------------------------------------------
// scc_step: per-item stuffing logic and sequence state
// Turns one registered input byte into zero, one or two result bytes and
// keeps the running crc and the pending escape flag.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              mode_i,      // 1: unstuff, 0: stuff
  input  wire logic              clear_i,     // config write restarts the sequence
  input  wire logic              advance_i,   // current item is taken this cycle
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_last_i,
  output scc_pkg::scc_pair_t     pair_o
);

  logic [7:0] crc_q, crc_d;
  logic       esc_q, esc_d;

  logic [7:0] crc_b;
  logic [7:0] crc_e1;
  logic [7:0] crc_e2;
  logic [7:0] second;
  logic [7:0] acc_new;
  logic       esc_new;

  // crc candidates
  always_comb begin
    crc_b  = scc_pkg::crc_next(crc_q, in_byte_i);
    crc_e1 = scc_pkg::crc_next(crc_q, scc_pkg::SymEsc);
    second = (in_byte_i == scc_pkg::SymSyn) ? scc_pkg::SymEscSyn : scc_pkg::SymEscEsc;
    crc_e2 = scc_pkg::crc_next(crc_e1, second);
  end

  // result selection
  always_comb begin
    pair_o  = '0;
    acc_new = crc_b;
    esc_new = 1'b0;
    if (!mode_i) begin
      if (in_byte_i == scc_pkg::SymSyn || in_byte_i == scc_pkg::SymEsc) begin
        pair_o.count = scc_pkg::CountTwo;
        pair_o.r0    = '{out_byte: scc_pkg::SymEsc, running_crc: crc_e1, is_last: 1'b0};
        pair_o.r1    = '{out_byte: second, running_crc: crc_e2, is_last: in_last_i};
        acc_new      = crc_e2;
      end else begin
        pair_o.count = scc_pkg::CountOne;
        pair_o.r0    = '{out_byte: in_byte_i, running_crc: crc_b, is_last: in_last_i};
      end
    end else if (esc_q) begin
      if (in_byte_i == scc_pkg::SymEscSyn) begin
        pair_o.count = scc_pkg::CountOne;
        pair_o.r0    = '{out_byte: scc_pkg::SymSyn, running_crc: crc_b, is_last: in_last_i};
      end else if (in_byte_i == scc_pkg::SymEscEsc) begin
        pair_o.count = scc_pkg::CountOne;
        pair_o.r0    = '{out_byte: scc_pkg::SymEsc, running_crc: crc_b, is_last: in_last_i};
      end else begin
        // escape followed by an ordinary byte: both pass unchanged
        pair_o.count = scc_pkg::CountTwo;
        pair_o.r0    = '{out_byte: scc_pkg::SymEsc, running_crc: crc_q, is_last: 1'b0};
        pair_o.r1    = '{out_byte: in_byte_i, running_crc: crc_b, is_last: in_last_i};
      end
    end else if (in_byte_i == scc_pkg::SymEsc && !in_last_i) begin
      // hold the escape back until the next byte
      pair_o.count = scc_pkg::CountNone;
      esc_new      = 1'b1;
    end else begin
      pair_o.count = scc_pkg::CountOne;
      pair_o.r0    = '{out_byte: in_byte_i, running_crc: crc_b, is_last: in_last_i};
    end
  end

  // next state
  always_comb begin
    crc_d = crc_q;
    esc_d = esc_q;
    if (clear_i) begin
      crc_d = '0;
      esc_d = 1'b0;
    end else if (advance_i) begin
      crc_d = in_last_i ? 8'h00 : acc_new;
      esc_d = in_last_i ? 1'b0 : esc_new;
    end
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      esc_q <= 1'b0;
    end else begin
      crc_q <= crc_d;
      esc_q <= esc_d;
    end
  end

  // a held escape only exists in unstuff mode
  a_esc_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> mode_i)
    else $error("escape pending in stuff mode");

  // an item without result only in unstuff mode
  a_none_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && pair_o.count == scc_pkg::CountNone |-> mode_i && !in_last_i)
    else $error("item dropped outside escape hold");

  // the final byte restarts the sequence
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && in_last_i |=> crc_q == 8'h00 && !esc_q)
    else $error("state not cleared after final byte");

endmodule

`default_nettype wire

### src/scc_obuf.sv
// ----------------------------------------------------------------------------
// scc_obuf: two-entry output buffer
// Takes the results of one item at once and hands them out one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_obuf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire scc_pkg::scc_pair_t   pair_i,
  output logic                      can_load_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output scc_pkg::scc_res_t         out_res_o
);

  logic              v0_q, v0_d;
  logic              v1_q, v1_d;
  scc_pkg::scc_res_t s0_q, s0_d;
  scc_pkg::scc_res_t s1_q, s1_d;
  logic              pop;

  assign pop         = v0_q && out_ready_i;
  assign can_load_o  = !v0_q || (pop && !v1_q);
  assign out_valid_o = v0_q;
  assign out_res_o   = s0_q;

  // slot update: load replaces, pop shifts down
  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    s0_d = s0_q;
    s1_d = s1_q;
    if (load_i) begin
      v0_d = (pair_i.count != scc_pkg::CountNone);
      v1_d = (pair_i.count == scc_pkg::CountTwo);
      s0_d = pair_i.r0;
      s1_d = pair_i.r1;
    end else if (pop) begin
      v0_d = v1_q;
      v1_d = 1'b0;
      s0_d = s1_q;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  // second slot never holds data alone
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q)
    else $error("second slot valid without first");

  // a load never overwrites results still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o && pair_i.count != 2'd3)
    else $error("output buffer overrun");

endmodule

`default_nettype wire

### src/symbol_stuffing_codec_crc8.sv
// ----------------------------------------------------------------------------
// symbol_stuffing_codec_crc8: byte stuffing codec with running crc-8
// Stuffs or unstuffs a byte stream and tags each result byte with the crc
// over the stuffed form.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_axis   | in        | tvalid / tready    | tdata[7:0] in_byte, tlast end
//  m_axis   | out       | tvalid / tready    | tdata[7:0] out_byte, [15:8] crc,
//           |           |                    | tlast is_last
//  cfg      | in        | cfg_valid/cfg_ready| cfg_data_i input_is_stuffed
//
//  an accepted byte waits in the input register, then its results load
//  the two-entry output buffer; results leave one per cycle unless stalled.
//  one result per item sustains one item per cycle unless stalled; with two
//  results the next item waits for the single output port of the buffer.
//  reset clears mode (stuff), crc, pending escape and all valid flags.
//  a stalled output holds the buffer, which then holds the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_stuffing_codec_crc8 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [15:8] running_crc
  output logic             m_axis_tlast,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i      // input_is_stuffed
);

  logic               mode_q;
  logic               cfg_wr;
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               can_load;
  logic               advance;
  scc_pkg::scc_pair_t pair;
  scc_pkg::scc_res_t  res;

  // configuration register
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr) begin
      mode_q <= cfg_data_i;
    end
  end

  // input register
  assign advance       = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // stuffing logic
  scc_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .clear_i   (cfg_wr),
    .advance_i (advance),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .pair_o    (pair)
  );

  // output buffer
  scc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .pair_i      (pair),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {res.running_crc, res.out_byte};
  assign m_axis_tlast = res.is_last;

endmodule

`default_nettype wire

### test/symbol_stuffing_codec_crc8_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// symbol_stuffing_codec_crc8_test: self-checking bench of the stuffing codec
// Drives raw and stuffed byte sequences in both directions, stalls both
// streams at random and checks every result byte, its crc and its end flag
// against an in-bench model of the codec kept in a small scoreboard.
// ----------------------------------------------------------------------------

module symbol_stuffing_codec_crc8_test;

  // expected result bytes and the codec state that produces them
  class stuffed_stream_board;
    scc_pkg::scc_res_t awaited_out[$];
    logic       unstuff_mode;
    logic [7:0] crc_acc;
    logic       esc_held;
    int         errors;

    function new();
      unstuff_mode = 1'b0;
      crc_acc      = 8'h00;
      esc_held     = 1'b0;
      errors       = 0;
    endfunction

    // crc-8 with the data bits shifted in msb first
    function logic [7:0] crc_after(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      logic       top;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        top = c[7];
        c = {c[6:0], b[i]};
        if (top) begin
          c = c ^ scc_pkg::CrcPoly;
        end
      end
      return c;
    endfunction

    function void push_out(logic [7:0] b, logic [7:0] crc);
      scc_pkg::scc_res_t r;
      r.out_byte    = b;
      r.running_crc = crc;
      r.is_last     = 1'b0;
      awaited_out = {awaited_out, r};
    endfunction

    // a register write drops the running sequence
    function void set_mode(logic m);
      unstuff_mode = m;
      crc_acc      = 8'h00;
      esc_held     = 1'b0;
    endfunction

    // work out the results of one accepted request
    function void take_in_byte(logic [7:0] b, logic last);
      logic [7:0] crc;
      logic [7:0] second;
      int         n;
      crc = crc_acc;
      n   = 0;
      if (!unstuff_mode) begin
        if (b == scc_pkg::SymSyn || b == scc_pkg::SymEsc) begin
          second = (b == scc_pkg::SymSyn) ? scc_pkg::SymEscSyn : scc_pkg::SymEscEsc;
          crc = crc_after(crc, scc_pkg::SymEsc);
          push_out(scc_pkg::SymEsc, crc);
          crc = crc_after(crc, second);
          push_out(second, crc);
          n = 2;
        end else begin
          crc = crc_after(crc, b);
          push_out(b, crc);
          n = 1;
        end
      end else if (esc_held) begin
        crc = crc_after(crc, b);
        esc_held = 1'b0;
        if (b == scc_pkg::SymEscSyn) begin
          push_out(scc_pkg::SymSyn, crc);
          n = 1;
        end else if (b == scc_pkg::SymEscEsc) begin
          push_out(scc_pkg::SymEsc, crc);
          n = 1;
        end else begin
          // unknown escape: both bytes pass unchanged
          push_out(scc_pkg::SymEsc, crc_acc);
          push_out(b, crc);
          n = 2;
        end
      end else begin
        crc = crc_after(crc, b);
        if (b == scc_pkg::SymEsc && !last) begin
          esc_held = 1'b1;
        end else begin
          push_out(b, crc);
          n = 1;
        end
      end
      if (last) begin
        if (n > 0) begin
          awaited_out[$].is_last = 1'b1;
        end
        crc_acc  = 8'h00;
        esc_held = 1'b0;
      end else begin
        crc_acc = crc;
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_out_byte(logic [7:0] b, logic [7:0] crc, logic last);
      scc_pkg::scc_res_t e;
      if (awaited_out.size() == 0) begin
        $display("%0t error: unexpected result byte %h crc %h last %b",
                 $time, b, crc, last);
        errors++;
        return;
      end
      e = awaited_out.pop_front();
      if (e.out_byte !== b) begin
        $display("%0t error: out_byte expected %h actual %h", $time, e.out_byte, b);
        errors++;
      end
      if (e.running_crc !== crc) begin
        $display("%0t error: running_crc expected %h actual %h",
                 $time, e.running_crc, crc);
        errors++;
      end
      if (e.is_last !== last) begin
        $display("%0t error: is_last expected %b actual %b", $time, e.is_last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  stuffed_stream_board board;

  // sender and receiver control
  bit offer_up  = 1'b0;
  bit gaps_on   = 1'b0;
  int burst_left = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int style     = 0;
  int style_left = 0;
  int rx_cycle  = 0;
  int sent      = 0;

  symbol_stuffing_codec_crc8 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      board.check_out_byte(m_tdata[7:0], m_tdata[15:8], m_tlast);
    end
  end

  // receiver: changing stall styles plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  task automatic stop_offer();
    if (offer_up) begin
      s_tvalid <= 1'b0;
      offer_up = 1'b0;
    end
  endtask

  // offer one request and wait for it to be taken
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    offer_up = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    board.take_in_byte(b, last);
    sent++;
    // bursts with random gaps between them
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          stop_offer();
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
  endtask

  // let every expected result arrive, then the tail of the pipeline settle
  task automatic drain();
    int n;
    stop_offer();
    n = 0;
    while (board.awaited_out.size() > 0 && n < 50000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_mode(m);
  endtask

  // bytes biased toward the stuffing symbols
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1: return scc_pkg::SymEsc;
      2: return scc_pkg::SymSyn;
      3: return scc_pkg::SymEscSyn;
      4: return scc_pkg::SymEscEsc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one random sequence; in unstuff mode mostly a well-formed stuffed stream
  task automatic send_sequence();
    logic [7:0] seq[$];
    logic [7:0] b;
    int         len;
    bit         clean;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    clean = board.unstuff_mode && ($urandom_range(0, 9) < 7);
    for (int i = 0; i < len; i++) begin
      b = pick_byte();
      if (clean && b == scc_pkg::SymSyn) begin
        seq = {seq, scc_pkg::SymEsc};
        seq = {seq, scc_pkg::SymEscSyn};
      end else if (clean && b == scc_pkg::SymEsc) begin
        seq = {seq, scc_pkg::SymEsc};
        seq = {seq, scc_pkg::SymEscEsc};
      end else begin
        seq = {seq, b};
      end
    end
    foreach (seq[i]) begin
      send_byte(seq[i], i == seq.size() - 1);
    end
  endtask

  // stimulus
  initial begin
    int target;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // stuffing direction after reset: extremes and both symbols
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(scc_pkg::SymSyn, 1'b0);
    send_byte(scc_pkg::SymEsc, 1'b0);
    send_byte(scc_pkg::SymEscSyn, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(scc_pkg::SymEsc, 1'b1);
    send_byte(scc_pkg::SymSyn, 1'b1);

    // unstuffing: both escapes, escape then escape, unknown escape
    write_mode(1'b1);
    send_byte(scc_pkg::SymEsc, 1'b0);
    send_byte(scc_pkg::SymEscSyn, 1'b0);
    send_byte(scc_pkg::SymEsc, 1'b0);
    send_byte(scc_pkg::SymEscEsc, 1'b0);
    send_byte(scc_pkg::SymEsc, 1'b0);
    send_byte(scc_pkg::SymEsc, 1'b0);
    send_byte(scc_pkg::SymEsc, 1'b0);
    send_byte(8'h55, 1'b0);
    // lone escape as the final byte
    send_byte(scc_pkg::SymEsc, 1'b1);
    // held escape resolved by the final byte
    send_byte(scc_pkg::SymEsc, 1'b0);
    send_byte(scc_pkg::SymEsc, 1'b1);
    send_byte(scc_pkg::SymEsc, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    // a register write drops a held escape
    send_byte(scc_pkg::SymEsc, 1'b0);
    write_mode(1'b1);
    send_byte(scc_pkg::SymEscSyn, 1'b1);
    write_mode(1'b0);
    send_byte(scc_pkg::SymEsc, 1'b0);
    write_mode(1'b1);

    // random phases, alternating direction
    for (int phase = 0; phase < 6; phase++) begin
      write_mode(phase % 2 == 0);
      gaps_on = (phase != 4);
      target  = sent + 250;
      if (phase == 1) begin
        // receiver holds off while the sender keeps offering
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        while (sent < target - 190) begin
          send_sequence();
        end
        gaps_on = 1'b1;
      end
      while (sent < target) begin
        send_sequence();
        if (phase == 3 && sent > target - 125 && sent < target - 100) begin
          // sender waits for every result before going on
          drain();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (board.awaited_out.size() > 0) begin
      $display("%0t error: %0d expected results never arrived, next expected byte %h",
               $time, board.awaited_out.size(), board.awaited_out[0].out_byte);
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
